### hdl/fifo_set_assoc_cache_prefetch_macros.svh
// Assertion macros for the set-associative cache block.
`ifndef FIFO_SET_ASSOC_CACHE_PREFETCH_MACROS_SVH
`define FIFO_SET_ASSOC_CACHE_PREFETCH_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSACP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSACP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSACP_ASSERT_IMP(label, clk, rst, ante, cons)
`define FSACP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/fsacp_pkg.sv
// Shared types and constants for the set-associative cache block.
package fsacp_pkg;
  localparam int unsigned CNT_W = 32;
  localparam logic [1:0] REG_WAYS = 2'd0;
  localparam logic [1:0] REG_INDEX = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_PREFETCH = 2'd3;

  // Counter increment requests from the sequencer.
  typedef struct packed {
    logic rd;
    logic wr;
    logic hit;
    logic miss;
  } cnt_inc_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_ADDR   = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_CMP    = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;
endpackage

### hdl/fsacp_counters.sv
// Saturating event counters.
module fsacp_counters (
  input  logic                    clk,
  input  logic                    rst,
  input  fsacp_pkg::cnt_inc_t     inc,
  output logic [fsacp_pkg::CNT_W-1:0] reads,
  output logic [fsacp_pkg::CNT_W-1:0] writes,
  output logic [fsacp_pkg::CNT_W-1:0] hits,
  output logic [fsacp_pkg::CNT_W-1:0] misses
);
  // Advance each count, hold at all ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      reads <= '0; writes <= '0; hits <= '0; misses <= '0;
    end else begin
      if (inc.rd && !(&reads)) reads <= reads + 1'b1;
      if (inc.wr && !(&writes)) writes <= writes + 1'b1;
      if (inc.hit && !(&hits)) hits <= hits + 1'b1;
      if (inc.miss && !(&misses)) misses <= misses + 1'b1;
    end
  end
endmodule

### hdl/fifo_set_assoc_cache_prefetch.sv
// Top level: set-associative tag store, FIFO replacement, next-line prefetch.
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata = byte_address, tuser = action
//  m_axis  | out | tvalid/tready    | tdata = {misses,hits,writes,reads}, tuser = {pf,hit}
//  cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
// A probe splits the address, then checks each way in turn (tag read, compare);
// a miss adds a fill and, with prefetch, a second probe. After reset a clearing
// pass over all 2**MAX_INDEX_BITS sets resets the replace pointers and valid rows;
// s_tready stays low during it.
// One access at a time; a result waits in the output register until taken.
`include "fifo_set_assoc_cache_prefetch_macros.svh"
module fifo_set_assoc_cache_prefetch #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_INDEX_BITS = 10,
  parameter int ADDR_BITS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((ADDR_BITS+7)/8)*8-1:0] s_axis_tdata, // byte_address, zero pad
  input  logic s_axis_tuser,                          // action
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [127:0] m_axis_tdata, // reads, writes, hits, misses
  output logic [1:0] m_axis_tuser,   // was_hit, prefetch_filled
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int NSETS = 1 << MAX_INDEX_BITS;
  localparam int LINE_W = SET_W + WAY_W;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  fsacp_pkg::state_t state;
  logic [3:0] ways_r, index_r, offset_r;
  logic pf_en;
  logic [WCNT_W-1:0] eff_ways;
  logic [3:0] eff_ib;

  // Tag memory, valid rows and pointers.
  logic [ADDR_BITS-1:0] tag_mem [0:(1 << LINE_W)-1];
  logic [MAX_WAYS-1:0] valid_mem [0:NSETS-1];
  logic [WAY_W-1:0] ptr_mem [0:NSETS-1];
  logic [ADDR_BITS-1:0] tag_q;
  logic [MAX_WAYS-1:0] vrow;
  logic [WAY_W-1:0] ptr_q;

  logic is_write, second, hit_f, pf_f;
  logic [ADDR_BITS-1:0] addr, tag;
  logic [SET_W-1:0] set_i, clr;
  logic [WCNT_W-1:0] way;
  fsacp_pkg::cnt_inc_t inc, inc_next;
  logic [31:0] c_rd, c_wr, c_hit, c_miss;
  logic [WAY_W-1:0] victim, vnext;
  logic last_way;
  logic cmp_hit;

  assign eff_ways = (ways_r == 4'd0) ? WCNT_W'(1) :
                    (32'(ways_r) > MAX_WAYS) ? WCNT_W'(MAX_WAYS) : WCNT_W'(ways_r);
  assign eff_ib = (32'(index_r) > MAX_INDEX_BITS) ? 4'(MAX_INDEX_BITS) : index_r;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = state == fsacp_pkg::ST_IDLE && !m_axis_tvalid;
  assign victim = (32'(ptr_q) >= 32'(eff_ways)) ? '0 : ptr_q;
  assign vnext = (32'(victim) + 1 >= 32'(eff_ways)) ? '0 : WAY_W'(victim + 1'b1);
  assign last_way = (way + 1'b1) >= eff_ways;
  assign cmp_hit = vrow[way[WAY_W-1:0]] && tag_q == tag;

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_r <= 4'd1; index_r <= 4'd0; offset_r <= 4'd6; pf_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fsacp_pkg::REG_WAYS: ways_r <= cfg_data;
        fsacp_pkg::REG_INDEX: index_r <= cfg_data;
        fsacp_pkg::REG_OFFSET: offset_r <= cfg_data;
        fsacp_pkg::REG_PREFETCH: pf_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memory ports: registered reads, single write per array.
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[{set_i, way[WAY_W-1:0]}];
    if (state == fsacp_pkg::ST_FILL) tag_mem[{set_i, victim}] <= tag;
  end
  always_ff @(posedge clk) begin
    if (state == fsacp_pkg::ST_READ) begin
      vrow <= valid_mem[set_i];
      ptr_q <= ptr_mem[set_i];
    end
    if (state == fsacp_pkg::ST_CLEAR) begin
      valid_mem[clr] <= '0;
      ptr_mem[clr] <= '0;
    end else if (state == fsacp_pkg::ST_FILL) begin
      valid_mem[set_i] <= vrow | (MAX_WAYS'(1) << victim);
      ptr_mem[set_i] <= vnext;
    end
  end

  // Counter requests: demand hit and write on compare, reads on every fill, demand miss and write on the first fill.
  always_comb begin
    inc_next = '0;
    if (state == fsacp_pkg::ST_CMP && cmp_hit && !second) begin
      inc_next.hit = 1'b1;
      inc_next.wr = is_write;
    end
    if (state == fsacp_pkg::ST_FILL) begin
      inc_next.rd = 1'b1;
      if (!second) begin
        inc_next.miss = 1'b1;
        inc_next.wr = is_write;
      end
    end
  end

  // Sequencer: clear after reset, split address, walk the ways, fill on a miss, then prefetch if enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsacp_pkg::ST_CLEAR;
      clr <= '0;
      m_axis_tvalid <= 1'b0;
      inc <= '0;
    end else begin
      inc <= inc_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        fsacp_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == NSETS - 1) state <= fsacp_pkg::ST_IDLE;
        end
        fsacp_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          is_write <= s_axis_tuser;
          addr <= s_axis_tdata[ADDR_BITS-1:0];
          second <= 1'b0;
          pf_f <= 1'b0;
          state <= fsacp_pkg::ST_ADDR;
        end
        fsacp_pkg::ST_ADDR: begin
          set_i <= SET_W'((addr >> offset_r) & ((ADDR_BITS'(1) << eff_ib) - 1'b1));
          tag <= addr >> (5'(offset_r) + 5'(eff_ib));
          way <= '0;
          state <= fsacp_pkg::ST_READ;
        end
        fsacp_pkg::ST_READ: state <= fsacp_pkg::ST_CMP;
        fsacp_pkg::ST_CMP: begin
          if (cmp_hit) begin
            if (!second) hit_f <= 1'b1;
            state <= fsacp_pkg::ST_DONE;
          end else if (!last_way) begin
            way <= way + 1'b1;
            state <= fsacp_pkg::ST_READ;
          end else state <= fsacp_pkg::ST_FILL;
        end
        fsacp_pkg::ST_FILL: begin
          if (second) begin
            pf_f <= 1'b1;
            state <= fsacp_pkg::ST_DONE;
          end else begin
            hit_f <= 1'b0;
            if (pf_en) begin
              second <= 1'b1;
              addr <= addr + (ADDR_BITS'(1) << offset_r);
              state <= fsacp_pkg::ST_ADDR;
            end else state <= fsacp_pkg::ST_DONE;
          end
        end
        fsacp_pkg::ST_DONE: begin
          m_axis_tvalid <= 1'b1;
          state <= fsacp_pkg::ST_IDLE;
        end
        default: state <= fsacp_pkg::ST_IDLE;
      endcase
    end
  end

  fsacp_counters u_cnt (
    .clk(clk), .rst(rst), .inc(inc),
    .reads(c_rd), .writes(c_wr), .hits(c_hit), .misses(c_miss)
  );

  // Output register: flags captured in DONE; counters take their last increment on the edge that raises valid.
  always_ff @(posedge clk) begin
    if (state == fsacp_pkg::ST_DONE) begin
      m_axis_tuser <= {pf_f, hit_f};
    end
  end
  assign m_axis_tdata = {c_miss, c_hit, c_wr, c_rd};

  `FSACP_ASSERT_IMP(a_no_accept_busy, clk, rst, state != fsacp_pkg::ST_IDLE, !s_axis_tready)
  `FSACP_ASSERT_NEXT(a_done_valid, clk, rst, state == fsacp_pkg::ST_DONE, m_axis_tvalid)
  `FSACP_ASSERT_IMP(a_pf_needs_miss, clk, rst, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
endmodule

### tb/fifo_set_assoc_cache_prefetch_tb.sv
// Self-checking testbench for the set-associative cache block with next-line prefetch.
module fifo_set_assoc_cache_prefetch_tb;

  localparam bit ACT_READ = 1'b0;
  localparam bit ACT_WRITE = 1'b1;
  localparam int TAG_WAYS = 8;
  localparam int TAG_SETS = 1024;

  typedef struct {
    bit hit;
    bit pf;
    bit [31:0] reads;
    bit [31:0] writes;
    bit [31:0] hits;
    bit [31:0] misses;
  } cache_result_t;

  // Shadow tag store: predicts counters and hit/prefetch flags per access.
  class cache_scoreboard;
    bit [47:0] tags[TAG_SETS*TAG_WAYS];
    bit valid[TAG_SETS*TAG_WAYS];
    bit [2:0] rr_ptr[TAG_SETS];
    bit [3:0] ways_reg = 4'd1;
    bit [3:0] index_reg = 4'd0;
    bit [3:0] offset_reg = 4'd6;
    bit prefetch_reg = 1'b0;
    bit [31:0] rd_cnt, wr_cnt, hit_cnt, miss_cnt;
    cache_result_t pending_q[$];
    int errors;

    function void set_reg(logic [1:0] idx, bit [3:0] val);
      case (idx)
        fsacp_pkg::REG_WAYS: ways_reg = val;
        fsacp_pkg::REG_INDEX: index_reg = val;
        fsacp_pkg::REG_OFFSET: offset_reg = val;
        fsacp_pkg::REG_PREFETCH: prefetch_reg = val[0];
        default: ;
      endcase
    endfunction

    function void bump(ref bit [31:0] c);
      if (c != 32'hFFFF_FFFF) c = c + 1;
    endfunction

    // Look up one block, place it round-robin on a miss; return hit.
    function bit lookup_fill(bit [47:0] a);
      int ib, nw, set, base, victim;
      bit [47:0] tag;
      ib = (index_reg > 10) ? 10 : index_reg;
      nw = (ways_reg == 0) ? 1 : ((ways_reg > TAG_WAYS) ? TAG_WAYS : ways_reg);
      set = int'((a >> offset_reg) & ((48'd1 << ib) - 48'd1));
      tag = a >> (offset_reg + ib);
      base = set * TAG_WAYS;
      for (int w = 0; w < nw; w++)
        if (valid[base+w] && tags[base+w] == tag) return 1'b1;
      victim = rr_ptr[set];
      if (victim >= nw) victim = 0;
      tags[base+victim] = tag;
      valid[base+victim] = 1'b1;
      victim++;
      if (victim >= nw) victim = 0;
      rr_ptr[set] = victim[2:0];
      return 1'b0;
    endfunction

    function void note_access(bit act, bit [47:0] a);
      cache_result_t r;
      bit [47:0] nxt;
      r.pf = 1'b0;
      r.hit = lookup_fill(a);
      if (r.hit) begin
        bump(hit_cnt);
        if (act == ACT_WRITE) bump(wr_cnt);
      end else begin
        bump(miss_cnt);
        bump(rd_cnt);
        if (act == ACT_WRITE) bump(wr_cnt);
        if (prefetch_reg) begin
          nxt = a + (48'd1 << offset_reg);
          if (!lookup_fill(nxt)) begin
            bump(rd_cnt);
            r.pf = 1'b1;
          end
        end
      end
      r.reads = rd_cnt;
      r.writes = wr_cnt;
      r.hits = hit_cnt;
      r.misses = miss_cnt;
      pending_q.push_back(r);
    endfunction

    function void cmp(string name, bit [31:0] e, bit [31:0] g);
      if (e !== g) begin
        $error("%s expected %0h actual %0h", name, e, g);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] user, logic [127:0] data);
      cache_result_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("was_hit", e.hit, user[0]);
      cmp("prefetch_filled", e.pf, user[1]);
      cmp("total_mem_reads", e.reads, data[31:0]);
      cmp("total_mem_writes", e.writes, data[63:32]);
      cmp("total_hits", e.hits, data[95:64]);
      cmp("total_misses", e.misses, data[127:96]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  cache_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  bit [47:0] pool[12];

  fifo_set_assoc_cache_prefetch i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Drive result ready: random stalls, quiet stretches, one long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 27);
    end
  end

  // Check every result beat.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  task automatic send_access(bit act, bit [47:0] a);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_access(act, a);
  endtask

  task automatic drop_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, bit [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the block has drained, then reprogram the geometry.
  task automatic set_geometry(bit [3:0] w, bit [3:0] ib, bit [3:0] off, bit pf);
    drop_input();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(fsacp_pkg::REG_WAYS, w);
    write_reg(fsacp_pkg::REG_INDEX, ib);
    write_reg(fsacp_pkg::REG_OFFSET, off);
    write_reg(fsacp_pkg::REG_PREFETCH, {3'b000, pf});
    foreach (pool[i]) pool[i] = 48'({$urandom(), $urandom()});
  endtask

  // Mostly reuse a small address pool so hits, evictions and prefetch hits occur.
  function automatic bit [47:0] pick_addr();
    bit [47:0] a;
    if ($urandom_range(0, 99) < 15) return 48'({$urandom(), $urandom()});
    a = pool[$urandom_range(0, 11)];
    a = a + (48'($urandom_range(0, 3)) << sb.offset_reg);
    a = a ^ (48'($urandom()) & ((48'd1 << sb.offset_reg) - 48'd1));
    return a;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_access($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, pick_addr());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset geometry, direct mapped, one set, 64-byte blocks.
    send_access(ACT_READ, 48'h0);
    send_access(ACT_WRITE, 48'h0);
    send_access(ACT_WRITE, 48'hFFFF_FFFF_FFFF);
    send_access(ACT_READ, 48'h3F);
    send_access(ACT_READ, 48'h40);
    send_access(ACT_WRITE, 48'h7F);

    // Directed: prefetch on, wrap of next block past the top of the address space.
    set_geometry(4'd4, 4'd2, 4'd4, 1'b1);
    send_access(ACT_READ, 48'hFFFF_FFFF_FFFF);
    send_access(ACT_READ, 48'h0);
    send_access(ACT_WRITE, 48'h100);
    send_access(ACT_READ, 48'h110);
    send_access(ACT_WRITE, 48'h110);
    send_access(ACT_READ, 48'hAAAA_5555_AAAA);
    send_access(ACT_WRITE, 48'h5555_AAAA_5555);
    random_phase(230);

    set_geometry(4'd8, 4'd10, 4'd0, 1'b1);
    quiet = 1'b1;
    random_phase(120);
    quiet = 1'b0;
    random_phase(120);

    // Out-of-range ways and index width, largest offset.
    set_geometry(4'd0, 4'd15, 4'd15, 1'b1);
    random_phase(200);

    set_geometry(4'd15, 4'd3, 4'd12, 1'b0);
    @(posedge clk);
    hold_req = 1'b1;
    random_phase(240);

    // Shrinking ways leaves pointers beyond the new way count.
    set_geometry(4'd2, 4'd1, 4'd6, 1'b1);
    random_phase(240);

    set_geometry(4'd3, 4'd10, 4'd2, 1'b1);
    random_phase(240);

    set_geometry(4'd8, 4'd4, 4'd6, 1'b0);
    random_phase(180);
    set_geometry(4'd1, 4'd0, 4'd0, 1'b1);
    random_phase(180);
    set_geometry(4'd7, 4'd6, 4'd9, 1'b1);
    random_phase(180);

    drop_input();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
